// ===== design/cle_pkg.sv =====
// Shared constants, item types and character codes for the console line editor.
package cle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int COUNT_W    = 6;
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 5;

    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic OUT_ECHO = 1'b0;
    localparam logic OUT_READ = 1'b1;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] read_index;
    } t_in;

    typedef struct packed {
        logic               out_kind;
        logic [BYTE_W-1:0]  out_byte;
        logic               last;
        logic               line_done;
        logic [COUNT_W-1:0] line_length;
    } t_out;

endpackage

// ===== design/cle_ram.sv =====
// Simple dual-port line store: one write port, one read port with registered data.
module cle_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/console_line_editor_with_echo_unit.sv =====
// Top level of the console line editor: sequencer, line counters and result register.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data  (cle_pkg::t_in)
//   out      output     o_out_valid / i_out_stall o_out_data (cle_pkg::t_out)
//
// An ordinary byte is stored at once; a backspace goes to S_TAIL, a read request to S_RWAIT.
// Each echoed byte goes through the store read loop (address, then data), once
// for every pending byte on an idle tick, and before the tail at an end of line.
// The single read port of the line store sets the pace of that loop.
// Reset clears the counters and the sequencer; the line store itself is not cleared.
// A stalled output holds the sequencer in the states that emit a beat; the input is stalled while it works.
module console_line_editor_with_echo_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cle_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cle_pkg::t_out o_out_data
);
    import cle_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ECHO  = 5'b00010,
        S_EWAIT = 5'b00100,
        S_TAIL  = 5'b01000,
        S_RWAIT = 5'b10000
    } t_state;

    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_MID   = 2'd1;
    localparam logic [1:0] STEP_LAST  = 2'd2;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_fill, n_fill;
    logic [COUNT_W-1:0] r_echoed, n_echoed;
    logic [COUNT_W-1:0] r_done_len, n_done_len;
    logic [COUNT_W-1:0] r_len, n_len;
    logic               r_eol, n_eol;
    logic [1:0]         r_step, n_step;
    logic               r_rd_hit, n_rd_hit;
    logic               r_out_valid;
    t_out               r_out;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               emit;
    t_out               emit_data;
    logic               out_free;
    logic               emit_fire;
    logic               fill_wrap;
    logic [COUNT_W-1:0] wr_pos;
    logic               echo_more;
    logic [COUNT_W-1:0] echo_next;
    logic [COUNT_W-1:0] idx_ext;

    cle_ram #(
        .DEPTH(LINE_DEPTH),
        .WIDTH(BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = emit && out_free;
    assign fill_wrap = (r_fill == COUNT_W'(LINE_DEPTH));
    assign wr_pos    = fill_wrap ? '0 : r_fill;
    // One compare and one increment are shared by every step of the echo loop.
    assign echo_more = (r_echoed < r_fill);
    assign echo_next = r_echoed + 1'b1;
    assign idx_ext   = COUNT_W'(i_in_data.read_index);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_echoed   = r_echoed;
        n_done_len = r_done_len;
        n_len      = r_len;
        n_eol      = r_eol;
        n_step     = r_step;
        n_rd_hit   = r_rd_hit;
        ram_we     = 1'b0;
        ram_waddr  = wr_pos[ADDR_W-1:0];
        ram_re     = 1'b0;
        ram_raddr  = r_echoed[ADDR_W-1:0];
        emit       = 1'b0;
        emit_data  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in_data.kind == KIND_BYTE) begin
                        priority if (i_in_data.rx_byte == CH_CR ||
                                     i_in_data.rx_byte == CH_LF) begin
                            n_eol   = 1'b1;
                            n_len   = r_fill;
                            n_state = S_ECHO;
                        end else if (i_in_data.rx_byte == CH_BS) begin
                            // A backspace on an empty line is dropped silently.
                            if (r_fill != '0) begin
                                n_fill = r_fill - 1'b1;
                                if (r_echoed != '0) begin
                                    n_echoed = r_echoed - 1'b1;
                                end
                                n_eol   = 1'b0;
                                n_step  = STEP_FIRST;
                                n_state = S_TAIL;
                            end
                        end else begin
                            // A full line restarts at the front; its unechoed bytes are lost.
                            ram_we = 1'b1;
                            n_fill = wr_pos + 1'b1;
                            if (fill_wrap) begin
                                n_echoed = '0;
                            end
                        end
                    end else if (i_in_data.kind == KIND_IDLE) begin
                        n_eol   = 1'b0;
                        n_state = S_ECHO;
                    end else if (i_in_data.kind == KIND_READ) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_ext[ADDR_W-1:0];
                        n_rd_hit  = (idx_ext < r_done_len);
                        n_state   = S_RWAIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ECHO: begin
                if (echo_more) begin
                    ram_re  = 1'b1;
                    n_state = S_EWAIT;
                end else if (r_eol) begin
                    n_step  = STEP_MID;
                    n_state = S_TAIL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EWAIT: begin
                emit                = 1'b1;
                emit_data.out_kind  = OUT_ECHO;
                emit_data.out_byte  = ram_rdata;
                emit_data.last      = !r_eol && (echo_next == r_fill);
                if (out_free) begin
                    n_echoed = echo_next;
                    n_state  = S_ECHO;
                end
            end
            S_TAIL: begin
                // End of line sends CR then LF; backspace sends BS, space, BS.
                emit               = 1'b1;
                emit_data.out_kind = OUT_ECHO;
                if (r_eol) begin
                    emit_data.out_byte = (r_step == STEP_LAST) ? CH_LF : CH_CR;
                end else begin
                    emit_data.out_byte = (r_step == STEP_MID) ? CH_SP : CH_BS;
                end
                emit_data.last        = (r_step == STEP_LAST);
                emit_data.line_done   = r_eol && (r_step == STEP_LAST);
                emit_data.line_length = (r_eol && (r_step == STEP_LAST)) ? r_len : '0;
                if (out_free) begin
                    n_step = r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        n_state = S_IDLE;
                        if (r_eol) begin
                            n_done_len = r_len;
                            n_fill     = '0;
                            n_echoed   = '0;
                        end
                    end
                end
            end
            S_RWAIT: begin
                emit               = 1'b1;
                emit_data.out_kind = OUT_READ;
                emit_data.out_byte = r_rd_hit ? ram_rdata : '0;
                emit_data.last     = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_echoed    <= '0;
            r_done_len  <= '0;
            r_eol       <= 1'b0;
            r_step      <= STEP_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_echoed    <= n_echoed;
            r_done_len  <= n_done_len;
            r_eol       <= n_eol;
            r_step      <= n_step;
            r_out_valid <= emit_fire || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_rd_hit <= n_rd_hit;
        if (emit_fire) begin
            r_out <= emit_data;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_echo_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_echoed <= r_fill)
        else $error("echoed count passed the fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= COUNT_W'(LINE_DEPTH))
        else $error("fill count beyond the line depth");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_done |-> o_out_data.last &&
        o_out_data.out_kind == OUT_ECHO && o_out_data.out_byte == CH_LF)
        else $error("line done flag on a beat that is not the closing LF");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAIL && r_eol && r_step == STEP_LAST && out_free |=>
        r_fill == '0 && r_echoed == '0)
        else $error("line counters not cleared after end of line");
`endif

endmodule
